FILE: hdl/pva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

  // action codes
  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;

  // outcome codes
  localparam logic [2:0] OC_IGNORED  = 3'd0;
  localparam logic [2:0] OC_FREE     = 3'd1;
  localparam logic [2:0] OC_RETRIG   = 3'd2;
  localparam logic [2:0] OC_STOLEN   = 3'd3;
  localparam logic [2:0] OC_RELEASED = 3'd4;
  localparam logic [2:0] OC_CLEARED  = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [1:0] voice;
    logic [2:0] outcome;
    logic [6:0] note_out;
    logic [6:0] velocity_out;
    logic [6:0] displaced_note;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic scan_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic steal_needed;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/pva_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pva_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pva_pkg::status_t status,
  output pva_pkg::cmd_t         cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    SCAN,
    COMMIT
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.load_in = in_valid;
      end
      EVAL: begin
        if (status.steal_needed) begin
          cmd.scan_start = 1'b1;
        end else begin
          cmd.commit = status.out_free;
        end
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
      end
      COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= EVAL;
        end
        EVAL: begin
          if (status.steal_needed) begin
            state <= SCAN;
          end else if (status.out_free) begin
            state <= IDLE;
          end
        end
        SCAN: begin
          if (status.scan_last) state <= COMMIT;
        end
        COMMIT: begin
          if (status.out_free) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pva_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pva_dp #(
  parameter int VOICES = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pva_pkg::in_t  in_data,
  input  wire pva_pkg::cmd_t cmd,
  output pva_pkg::status_t   status,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pva_pkg::out_t      out_data
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

  pva_pkg::in_t       in_q;
  logic [6:0]         voice_note [VOICES];
  logic [31:0]        voice_start [VOICES];
  logic [VOICES-1:0]  voice_active;

  logic [IW-1:0]      scan_idx;
  logic [IW-1:0]      best_idx;
  logic [31:0]        best_time;

  logic [VOICES-1:0]  match_vec;
  logic               any_match;
  logic               any_free;
  logic [IW-1:0]      match_idx;
  logic [IW-1:0]      free_idx;
  logic               is_clear;
  logic               is_release;
  logic               is_on;
  logic               steal;
  logic [IW-1:0]      pick_idx;
  logic [IW+1:0]      pick_wide;
  pva_pkg::out_t      res;

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      match_vec[i] = voice_active[i] && (voice_note[i] == in_q.note);
    end
  end

  // lowest index wins: scan from the top down
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IW'(i);
      if (!voice_active[i]) free_idx = IW'(i);
    end
  end

  assign any_match  = |match_vec;
  assign any_free   = ~&voice_active;
  assign is_clear   = (in_q.action == pva_pkg::ACT_CLEAR);
  assign is_release = (in_q.action == pva_pkg::ACT_NOTE_OFF) ||
                      ((in_q.action == pva_pkg::ACT_NOTE_ON) && (in_q.velocity == 7'd0));
  assign is_on      = (in_q.action == pva_pkg::ACT_NOTE_ON) && (in_q.velocity != 7'd0);
  assign steal      = is_on && !any_match && !any_free;

  always_comb begin
    priority if (any_match) begin
      pick_idx = match_idx;
    end else if (any_free) begin
      pick_idx = free_idx;
    end else begin
      pick_idx = best_idx;
    end
  end

  assign pick_wide = {2'b00, pick_idx};

  always_comb begin
    res = '0;
    priority if (is_clear) begin
      res.outcome = pva_pkg::OC_CLEARED;
    end else if (is_release) begin
      if (any_match) begin
        res.voice    = pick_wide[1:0];
        res.outcome  = pva_pkg::OC_RELEASED;
        res.note_out = in_q.note;
      end
    end else if (is_on) begin
      res.voice        = pick_wide[1:0];
      res.note_out     = in_q.note;
      res.velocity_out = in_q.velocity;
      priority if (any_match) begin
        res.outcome = pva_pkg::OC_RETRIG;
      end else if (any_free) begin
        res.outcome = pva_pkg::OC_FREE;
      end else begin
        res.outcome        = pva_pkg::OC_STOLEN;
        res.displaced_note = voice_note[best_idx];
      end
    end else begin
      // unused action code: result stays all zero
    end
  end

  assign status.steal_needed = steal;
  assign status.scan_last    = (scan_idx == IW'(VOICES - 1));
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_q <= in_data;
  end

  // oldest search: one voice per beat of the scan
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_idx  <= '0;
      best_time <= voice_start[0];
      scan_idx  <= IW'(1);
    end else if (cmd.scan_step) begin
      if (voice_start[scan_idx] < best_time) begin
        best_idx  <= scan_idx;
        best_time <= voice_start[scan_idx];
      end
      scan_idx <= scan_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && is_on) begin
      voice_note[pick_idx]  <= in_q.note;
      voice_start[pick_idx] <= in_q.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
    end else if (cmd.commit) begin
      priority if (is_clear) begin
        voice_active <= '0;
      end else if (is_release) begin
        if (any_match) voice_active[match_idx] <= 1'b0;
      end else if (is_on) begin
        voice_active[pick_idx] <= 1'b1;
      end else begin
        // unused action code: hold the pool
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data <= res;
  end

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while the result register is still full");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_note_on_leaves_active: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && is_on) |=> (voice_active != '0))
    else $error("note on left no voice active");

  a_steal_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> (&voice_active))
    else $error("oldest search started with a free voice");

endmodule

`default_nettype wire

FILE: hdl/poly_voice_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow: an accepted event is evaluated in EVAL and committed once the output register is
//   free; a steal first runs the oldest search in SCAN (one voice a cycle), then COMMIT.
// A new event is accepted only in IDLE, after the previous one is committed; the next
//   event is taken while the previous result waits in the output register.
// Reset: synchronous; frees all voices, returns the controller to idle, empties output.
module poly_voice_allocator #(
  parameter int VOICES = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pva_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pva_pkg::out_t      out_data
);

  pva_pkg::cmd_t    cmd;
  pva_pkg::status_t status;

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
